@@ design/crv_pkg.sv @@
package crv_pkg;

	localparam int HEADER_BYTES = 24;
	localparam int MAX_PAYLOAD  = 1024;
	localparam int HDR_CRC_AT   = 20;
	localparam int SECTOR_W     = 17;

	localparam logic [31:0] CRC_POLY   = 32'hedb88320;
	localparam logic [31:0] CRC_INIT   = 32'hffffffff;

	localparam logic [SECTOR_W-1:0] SECTOR_RESET = 17'd4096;

	// register indexes on the apb port
	localparam logic REG_SECTOR = 1'b0;

	// verdict codes, first failing check wins
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_MAGIC       = 4'd1;
	localparam logic [3:0] ST_VERSION     = 4'd2;
	localparam logic [3:0] ST_HDR_SIZE    = 4'd3;
	localparam logic [3:0] ST_HDR_CRC     = 4'd4;
	localparam logic [3:0] ST_PAYLOAD_LEN = 4'd5;
	localparam logic [3:0] ST_SCHEMA      = 4'd6;
	localparam logic [3:0] ST_SECTOR_FIT  = 4'd7;
	localparam logic [3:0] ST_PAYLOAD_CRC = 4'd8;

	typedef struct packed {
		logic       new_scan;
		logic       copy_index;
		logic       start_of_record;
		logic [7:0] data_byte;
	} crv_beat_t;

	typedef struct packed {
		logic        valid;
		logic        record_valid;
		logic [3:0]  status;
		logic        source_copy;
		logic [15:0] payload_length;
		logic [15:0] schema_id;
		logic [31:0] generation_count;
		logic [31:0] payload_checksum;
		logic        any_held;
		logic        active_copy;
	} crv_result_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h53;
			2'd1: m = 8'h50;
			2'd2: m = 8'h43;
			2'd3: m = 8'h46;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// serial-number compare: cand strictly newer than cur
	function automatic logic newer(input logic [31:0] cand, input logic [31:0] cur);
		logic [31:0] d;
		d = cand - cur;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

@@ design/config_record_validator.sv @@
// channel | dir | beat contents
// apb     | in  | psel/penable/pwrite/paddr/pwdata, prdata; sector_bytes at 0x0
// s_axis  | in  | one record byte per beat, tuser = start/copy/new_scan flags
// m_axis  | out | one verdict per judged record with header fields and held copy
//
// each byte beat passes an input register (_s1) and the combinational parse logic
// (byte-wide crc-32 and header checks), so one beat per cycle is sustained while not stalled
// a verdict is registered in the output register when the parse stage takes its last byte
// m_tready low holds the verdict; the input register keeps taking a beat until
// it is full, then s_tready drops
// reset (arst_n low, asynchronous) puts the parser idle, clears the held copy
// and sets sector_bytes to 4096
module config_record_validator import crv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// byte stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,    // [7:0] data_byte
	input  logic [2:0]   s_tuser,    // [0] start_of_record, [1] copy_index, [2] new_scan
	// verdict stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] source_copy, [16:1] payload_length, [32:17] schema_id,
	// [64:33] generation_count, [96:65] payload_checksum, [97] any_held,
	// [98] active_copy, [103:99] zero
	output logic [103:0] m_tdata,
	output logic [4:0]   m_tuser     // [0] record_valid, [4:1] status
);

	logic [SECTOR_W-1:0] sector_bytes;
	logic                valid_s1;
	crv_beat_t           beat_s1;
	logic                advance;
	crv_result_t         result;
	logic                out_valid_q;
	crv_result_t         out_q;

	crv_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sector_bytes (sector_bytes)
	);

	// parse stage moves only when the output register can take a verdict
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1.data_byte       <= s_tdata;
			beat_s1.start_of_record <= s_tuser[0];
			beat_s1.copy_index      <= s_tuser[1];
			beat_s1.new_scan        <= s_tuser[2];
		end
	end

	crv_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (valid_s1 && advance),
		.beat         (beat_s1),
		.sector_bytes (sector_bytes),
		.result       (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_q.status, out_q.record_valid};
	assign m_tdata  = {5'd0, out_q.active_copy, out_q.any_held, out_q.payload_checksum,
		out_q.generation_count, out_q.schema_id, out_q.payload_length, out_q.source_copy};

	// a passing verdict carries status ok and a failing one does not
	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[4:1] == ST_OK)))
		else $error("record_valid disagrees with status");

	// a passing record always leaves some copy held
	a_ok_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tdata[97])
		else $error("valid record not held");

	// active copy is zero while nothing is held
	a_active_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[98]) |-> m_tdata[97])
		else $error("active_copy set with nothing held");

	// a stalled input register keeps its byte
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(beat_s1)))
		else $error("input register overwritten while stalled");

endmodule

@@ design/crv_apb_regs.sv @@
module crv_apb_regs import crv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [SECTOR_W-1:0] sector_bytes
);

	logic [SECTOR_W-1:0] sector_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= SECTOR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SECTOR)) begin
			sector_q <= pwdata[SECTOR_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_SECTOR) begin
			prdata = {{(32-SECTOR_W){1'b0}}, sector_q};
		end
	end

	assign sector_bytes = sector_q;

endmodule

@@ design/crv_parser.sv @@
module crv_parser import crv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  crv_beat_t           beat,
	input  logic [SECTOR_W-1:0] sector_bytes,
	output crv_result_t         result
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  phase_q, ph;
	logic [15:0] pos_q, pos, p;
	logic [31:0] crc_q, crc;
	logic [3:0]  ff_q, ff;
	logic [15:0] len_q, len;
	logic [15:0] schema_q, schema;
	logic [31:0] gen_q, gen;
	logic [31:0] pcrc_q, pcrc;
	logic [31:0] hcrc_q, hcrc;
	logic        copy_q, copy;
	logic        hv_q, hv;
	logic [31:0] hg_q, hg;
	logic        hc_q, hc;
	logic        emit, take;
	logic [7:0]  b;

	assign b = beat.data_byte;

	always_comb begin
		ph     = phase_q;
		pos    = pos_q;
		crc    = crc_q;
		ff     = ff_q;
		len    = len_q;
		schema = schema_q;
		gen    = gen_q;
		pcrc   = pcrc_q;
		hcrc   = hcrc_q;
		copy   = copy_q;
		hv     = hv_q;
		hg     = hg_q;
		hc     = hc_q;
		emit   = 1'b0;
		take   = 1'b0;
		p      = 16'd0;

		if (beat.start_of_record) begin
			if (beat.new_scan) begin
				hv = 1'b0;
				hg = 32'd0;
				hc = 1'b0;
			end
			copy   = beat.copy_index;
			ph     = PH_HEADER;
			pos    = 16'd0;
			crc    = CRC_INIT;
			ff     = ST_OK;
			len    = 16'd0;
			schema = 16'd0;
			gen    = 32'd0;
			pcrc   = 32'd0;
			hcrc   = 32'd0;
		end

		case (ph)
			PH_HEADER: begin
				p = pos;
				if (p < 16'(HDR_CRC_AT)) begin
					crc = crc_byte(crc, b);
				end
				if (p < 16'd4) begin
					if (b != magic_byte(p[1:0]) && ff == ST_OK) ff = ST_MAGIC;
				end else if (p == 16'd4) begin
					if (b != 8'd1 && ff == ST_OK) ff = ST_VERSION;
				end else if (p == 16'd5) begin
					if (b != 8'd0 && ff == ST_OK) ff = ST_VERSION;
				end else if (p == 16'd6) begin
					if (b != 8'(HEADER_BYTES) && ff == ST_OK) ff = ST_HDR_SIZE;
				end else if (p == 16'd7) begin
					if (b != 8'd0 && ff == ST_OK) ff = ST_HDR_SIZE;
				end else if (p < 16'd10) begin
					len = len | (16'(b) << {p[0], 3'b000});
				end else if (p < 16'd12) begin
					schema = schema | (16'(b) << {p[0], 3'b000});
				end else if (p < 16'd16) begin
					gen = gen | (32'(b) << {p[1:0], 3'b000});
				end else if (p < 16'd20) begin
					pcrc = pcrc | (32'(b) << {p[1:0], 3'b000});
				end else if (p < 16'(HEADER_BYTES)) begin
					hcrc = hcrc | (32'(b) << {p[1:0], 3'b000});
				end
				pos = p + 16'd1;
				if (p == 16'(HEADER_BYTES - 1)) begin
					if ((crc ^ CRC_INIT) != hcrc && ff == ST_OK) ff = ST_HDR_CRC;
					if ((len == 16'd0 || len > 16'(MAX_PAYLOAD)) && ff == ST_OK)
						ff = ST_PAYLOAD_LEN;
					if (schema == 16'd0 && ff == ST_OK) ff = ST_SCHEMA;
					if ((SECTOR_W'(HEADER_BYTES) + {1'b0, len}) > sector_bytes && ff == ST_OK)
						ff = ST_SECTOR_FIT;
					if (ff != ST_OK) begin
						emit = 1'b1;
						ph   = PH_IDLE;
					end else begin
						ph  = PH_PAYLOAD;
						pos = 16'd0;
						crc = CRC_INIT;
					end
				end
			end
			PH_PAYLOAD: begin
				crc = crc_byte(crc, b);
				pos = pos + 16'd1;
				if (pos >= len) begin
					if ((crc ^ CRC_INIT) != pcrc && ff == ST_OK) ff = ST_PAYLOAD_CRC;
					emit = 1'b1;
					ph   = PH_IDLE;
				end
			end
			default: ;
		endcase

		// newest-copy selection (a record of the held copy always replaces it), equal generations favor copy 0
		if (emit && ff == ST_OK) begin
			if (!hv || hc == copy) take = 1'b1;
			else if (copy) take = newer(gen, hg);
			else take = !newer(hg, gen);
			if (take) begin
				hv = 1'b1;
				hg = gen;
				hc = copy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= 16'd0;
			crc_q    <= CRC_INIT;
			ff_q     <= ST_OK;
			len_q    <= 16'd0;
			schema_q <= 16'd0;
			gen_q    <= 32'd0;
			pcrc_q   <= 32'd0;
			hcrc_q   <= 32'd0;
			copy_q   <= 1'b0;
			hv_q     <= 1'b0;
			hg_q     <= 32'd0;
			hc_q     <= 1'b0;
		end else if (step) begin
			phase_q  <= ph;
			pos_q    <= pos;
			crc_q    <= crc;
			ff_q     <= ff;
			len_q    <= len;
			schema_q <= schema;
			gen_q    <= gen;
			pcrc_q   <= pcrc;
			hcrc_q   <= hcrc;
			copy_q   <= copy;
			hv_q     <= hv;
			hg_q     <= hg;
			hc_q     <= hc;
		end
	end

	always_comb begin
		result.valid            = step && emit;
		result.record_valid     = (ff == ST_OK);
		result.status           = ff;
		result.source_copy      = copy;
		result.payload_length   = len;
		result.schema_id        = schema;
		result.generation_count = gen;
		result.payload_checksum = pcrc;
		result.any_held         = hv;
		result.active_copy      = hv && hc;
	end

endmodule
